@@ rtl/flash_wear_level_placer_unit_defines.svh @@
// Assertion macros shared by the flash wear-level placer RTL.
`ifndef FLASH_WEAR_LEVEL_PLACER_UNIT_DEFINES_SVH
`define FLASH_WEAR_LEVEL_PLACER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FLWP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("flwp check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define FLWP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("flwp check failed: next-cycle implication");

`endif

@@ rtl/flwp_pkg.sv @@
// Types, constants and helpers shared by the wear-level placer modules.
`default_nettype none
package flwp_pkg;

	localparam int NUM_SECTORS  = 8;
	localparam int SEC_W        = $clog2(NUM_SECTORS);
	localparam int SECTOR_BYTES = 4096;
	localparam int FILL_W       = $clog2(SECTOR_BYTES + 1);
	localparam int LEN_W        = 13;
	localparam int CNT_W        = 32;
	localparam int SUM_W        = ((FILL_W > LEN_W) ? FILL_W : LEN_W) + 1;

	localparam logic [SUM_W-1:0] SECTOR_LIMIT = SUM_W'(SECTOR_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX      = '1;
	localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(1000);
	localparam logic [SEC_W-1:0] LAST_SECTOR  = SEC_W'(NUM_SECTORS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEED,
		ST_SCAN,
		ST_DECIDE,
		ST_WRITE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // take the request, read the active sector
		logic check;   // judge the active sector, read its successor
		logic seed;    // successor becomes the first candidate
		logic scan;    // compare one scanned sector
		logic write;   // commit the placement
		logic refuse;  // report a refused request
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rotate;
		logic scan_last;
		logic best_fits;
	} stat_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

	function automatic logic fits(input logic [FILL_W-1:0] fill,
	                              input logic [LEN_W-1:0] len);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(fill) + SUM_W'(len);
		return sum <= SECTOR_LIMIT;
	endfunction

endpackage
`default_nettype wire

@@ rtl/flwp_ctrl.sv @@
// Sequencer for one placement: check, optional rotation scan, commit or refuse.
`default_nettype none
module flwp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire flwp_pkg::stat_t stat,
	output flwp_pkg::cmd_t     cmd,
	output logic               busy
);

	flwp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flwp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			flwp_pkg::ST_IDLE: begin
				if (start) state_d = flwp_pkg::ST_CHECK;
			end
			flwp_pkg::ST_CHECK: begin
				state_d = stat.rotate ? flwp_pkg::ST_SEED : flwp_pkg::ST_WRITE;
			end
			flwp_pkg::ST_SEED: begin
				state_d = flwp_pkg::ST_SCAN;
			end
			flwp_pkg::ST_SCAN: begin
				if (stat.scan_last) state_d = flwp_pkg::ST_DECIDE;
			end
			flwp_pkg::ST_DECIDE: begin
				state_d = stat.best_fits ? flwp_pkg::ST_WRITE : flwp_pkg::ST_IDLE;
			end
			flwp_pkg::ST_WRITE: begin
				state_d = flwp_pkg::ST_IDLE;
			end
			default: begin
				state_d = flwp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			flwp_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			flwp_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
			end
			flwp_pkg::ST_SEED: begin
				cmd.seed = 1'b1;
			end
			flwp_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			flwp_pkg::ST_DECIDE: begin
				cmd.refuse = !stat.best_fits;
			end
			flwp_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/flwp_dpath.sv @@
// Sector store, candidate scan registers, threshold register and result registers.
`default_nettype none
module flwp_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire flwp_pkg::cmd_t               cmd,
	output flwp_pkg::stat_t                   stat,
	input  wire logic [flwp_pkg::LEN_W-1:0]   length,
	input  wire logic                         cfg_valid,
	input  wire logic [flwp_pkg::CNT_W-1:0]   cfg_data,
	output logic                              done,
	output logic                              accepted,
	output logic [flwp_pkg::SEC_W-1:0]        sector,
	output logic [flwp_pkg::FILL_W-1:0]       offset,
	output logic [flwp_pkg::CNT_W-1:0]        sector_writes
);

	// sector store: one read and one write port, unwritten entries read as zero
	flwp_pkg::entry_t mem [flwp_pkg::NUM_SECTORS];
	logic [flwp_pkg::NUM_SECTORS-1:0] vld_q;
	flwp_pkg::entry_t rdata_q;
	logic [flwp_pkg::SEC_W-1:0] rd_addr;

	logic [flwp_pkg::CNT_W-1:0]  thresh_q;
	logic [flwp_pkg::SEC_W-1:0]  active_q;
	logic [flwp_pkg::LEN_W-1:0]  len_q;
	logic [flwp_pkg::SEC_W-1:0]  scan_q;
	logic [flwp_pkg::SEC_W-1:0]  rd_idx_s1;
	logic [flwp_pkg::SEC_W-1:0]  best_idx_q;
	logic [flwp_pkg::FILL_W-1:0] best_fill_q;
	logic [flwp_pkg::CNT_W-1:0]  best_cnt_q;
	logic [flwp_pkg::CNT_W-1:0]  act_cnt_q;

	logic [flwp_pkg::SEC_W-1:0]  next_idx;
	logic [flwp_pkg::CNT_W-1:0]  cnt_inc;
	logic [flwp_pkg::SUM_W-1:0]  fill_sum;
	flwp_pkg::entry_t            wdata;
	logic                        better;

	logic                        done_q;
	logic                        accepted_q;
	logic [flwp_pkg::SEC_W-1:0]  sector_q;
	logic [flwp_pkg::FILL_W-1:0] offset_q;
	logic [flwp_pkg::CNT_W-1:0]  writes_q;

	assign next_idx = (active_q == flwp_pkg::LAST_SECTOR) ? '0 : active_q + 1'b1;
	assign cnt_inc  = (best_cnt_q == flwp_pkg::CNT_MAX) ? best_cnt_q : best_cnt_q + 1'b1;
	assign fill_sum = flwp_pkg::SUM_W'(best_fill_q) + flwp_pkg::SUM_W'(len_q);
	assign wdata.fill = fill_sum[flwp_pkg::FILL_W-1:0];
	assign wdata.cnt  = cnt_inc;
	assign better     = (rd_idx_s1 != active_q) && (rdata_q.cnt < best_cnt_q);

	assign stat.rotate    = (rdata_q.cnt >= thresh_q) || !flwp_pkg::fits(rdata_q.fill, len_q);
	assign stat.scan_last = (rd_idx_s1 == flwp_pkg::LAST_SECTOR);
	assign stat.best_fits = flwp_pkg::fits(best_fill_q, len_q);

	always_comb begin
		rd_addr = active_q;
		if (cmd.check) begin
			rd_addr = next_idx;
		end else if (cmd.seed || cmd.scan) begin
			rd_addr = scan_q;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		if (cmd.write) mem[best_idx_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			thresh_q <= flwp_pkg::THRESH_RESET;
			active_q <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_valid) thresh_q <= cfg_data;
			if (cmd.write) begin
				vld_q[best_idx_q] <= 1'b1;
				active_q          <= best_idx_q;
			end
			done_q <= cmd.write || cmd.refuse;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) len_q <= length;
		if (cmd.check) begin
			act_cnt_q   <= rdata_q.cnt;
			best_idx_q  <= active_q;
			best_fill_q <= rdata_q.fill;
			best_cnt_q  <= rdata_q.cnt;
			scan_q      <= '0;
		end
		if (cmd.seed) begin
			best_idx_q  <= next_idx;
			best_fill_q <= rdata_q.fill;
			best_cnt_q  <= rdata_q.cnt;
		end
		if (cmd.seed || cmd.scan) begin
			scan_q    <= scan_q + 1'b1;
			rd_idx_s1 <= scan_q;
		end
		if (cmd.scan && better) begin
			best_idx_q  <= rd_idx_s1;
			best_fill_q <= rdata_q.fill;
			best_cnt_q  <= rdata_q.cnt;
		end
		if (cmd.write) begin
			accepted_q <= 1'b1;
			sector_q   <= best_idx_q;
			offset_q   <= best_fill_q;
			writes_q   <= cnt_inc;
		end else if (cmd.refuse) begin
			accepted_q <= 1'b0;
			sector_q   <= active_q;
			offset_q   <= '0;
			writes_q   <= act_cnt_q;
		end
	end

	assign done          = done_q;
	assign accepted      = accepted_q;
	assign sector        = sector_q;
	assign offset        = offset_q;
	assign sector_writes = writes_q;

endmodule
`default_nettype wire

@@ rtl/flash_wear_level_placer_unit.sv @@
// Top level of the flash wear-level placer: controller plus datapath.
//
//  channel   handshake                 payload
//  request   start && !busy            length
//  result    done (one-cycle strobe)   accepted, sector, offset, sector_writes
//  config    cfg_valid && cfg_ready    cfg_data (wear threshold)
//
// A request that stays on the active sector passes from accept through the check
// and write states to done. A rotation reads the successor and then scans all 8
// sectors through the single store read port, one per cycle. Reset clears the
// active sector, fill positions, write counts and sets the threshold to 1000;
// the store needs no clearing pass. The result strobe cannot be stalled; the next
// request may start in its cycle.
`default_nettype none
`include "flash_wear_level_placer_unit_defines.svh"
module flash_wear_level_placer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [flwp_pkg::LEN_W-1:0]  length,
	output logic                             done,
	output logic                             accepted,
	output logic [flwp_pkg::SEC_W-1:0]       sector,
	output logic [flwp_pkg::FILL_W-1:0]      offset,
	output logic [flwp_pkg::CNT_W-1:0]       sector_writes,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [flwp_pkg::CNT_W-1:0]  cfg_data
);

	flwp_pkg::cmd_t  cmd;
	flwp_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	flwp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	flwp_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.length        (length),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.accepted      (accepted),
		.sector        (sector),
		.offset        (offset),
		.sector_writes (sector_writes)
	);

	`FLWP_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
	`FLWP_ASSERT_NOW(a_done_when_idle, done, !busy)
	`FLWP_ASSERT_NOW(a_placed_counts, done && accepted, sector_writes != '0)
	`FLWP_ASSERT_NOW(a_refused_offset, done && !accepted, offset == '0)
	`FLWP_ASSERT_NOW(a_commit_fits, cmd.write, stat.best_fits)

endmodule
`default_nettype wire
